>>> rtl/core/xcfv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfv_pkg
// Types and constants shared by the XOR-checked frame validator.
// ----------------------------------------------------------------------------
package xcfv_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned VERDICT_W = 2;
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned OUT_DW    = 16;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [VERDICT_W-1:0] verdict_t;

  // Reset values of the header registers.
  localparam byte_t HEADER_FIRST_RST  = 8'hEA;
  localparam byte_t HEADER_SECOND_RST = 8'hEB;
  localparam byte_t HEADER_THIRD_RST  = 8'hEF;

  localparam byte_t PAYLOAD_SEED = 8'h11;
  localparam byte_t MIN_LENGTH   = 8'd7;

  // Byte positions with fixed meaning.
  localparam byte_t POS_HDR_FIRST  = 8'd0;
  localparam byte_t POS_HDR_SECOND = 8'd1;
  localparam byte_t POS_HDR_THIRD  = 8'd2;
  localparam byte_t POS_LENGTH     = 8'd3;
  localparam byte_t POS_PAYLOAD    = 8'd4;

  // Verdict codes.
  localparam verdict_t V_VALID      = 2'd0;
  localparam verdict_t V_BAD_HEADER = 2'd1;
  localparam verdict_t V_CHECK_BAD  = 2'd2;
  localparam verdict_t V_SHORT      = 2'd3;

  // Register indexes (word address bits [3:2]).
  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_HEADER_THIRD  = 2'd2;

endpackage

>>> rtl/core/xor_checked_frame_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_frame_validator
// Checks header, length and two XOR check bytes of byte-serial frames.
// ----------------------------------------------------------------------------
// The block takes one word per cycle unless the input stalls, and gives one
// verdict per frame in the cycle after the byte that decides it: the failing
// header byte, the length byte when the length is below seven, or the last
// check byte. All the work for a byte is an XOR and a compare between the
// frame state registers and a single result register. The output register
// takes a new verdict in the same cycle as the sink takes the waiting one, and
// the input stalls only while the sink holds off a pending verdict.
// A word with the start flag abandons any frame underway without a verdict.
module xor_checked_frame_validator
  import xcfv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Input stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] byte_value
  input  logic                s_tuser,   // [0] frame_start
  // Verdict stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_DW-1:0]   m_tdata,   // [1:0] verdict, [9:2] frame_length
  // Register port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  byte_t header_first, header_second, header_third;

  logic  active, active_next;
  byte_t position, position_next;
  byte_t length_seen, length_seen_next;
  byte_t xor_whole, xor_whole_next;
  byte_t xor_payload, xor_payload_next;
  logic  first_check_failed, first_check_failed_next;

  logic     out_valid;
  verdict_t out_verdict, out_verdict_next;
  byte_t    out_length, out_length_next;
  logic     emit;

  logic  fire;
  logic  cfg_write;
  byte_t cur_pos, cur_len, cur_xw, cur_xp, want;
  logic  cur_fcf, cur_active;

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_FIRST_RST;
      header_second <= HEADER_SECOND_RST;
      header_third  <= HEADER_THIRD_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_HEADER_FIRST:  header_first  <= pwdata[7:0];
        REG_HEADER_SECOND: header_second <= pwdata[7:0];
        REG_HEADER_THIRD:  header_third  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HEADER_FIRST:  prdata = {{(APB_DW-BYTE_W){1'b0}}, header_first};
      REG_HEADER_SECOND: prdata = {{(APB_DW-BYTE_W){1'b0}}, header_second};
      REG_HEADER_THIRD:  prdata = {{(APB_DW-BYTE_W){1'b0}}, header_third};
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Frame tracking
  // --------------------------------------------------------------------------
  assign s_tready = ~out_valid | m_tready;
  assign fire     = s_tvalid & s_tready;

  // A start word sees a freshly cleared frame state.
  always_comb begin
    cur_active = active | s_tuser;
    cur_pos    = s_tuser ? '0 : position;
    cur_len    = s_tuser ? '0 : length_seen;
    cur_xw     = s_tuser ? '0 : xor_whole;
    cur_xp     = s_tuser ? '0 : xor_payload;
    cur_fcf    = s_tuser ? 1'b0 : first_check_failed;
  end

  always_comb begin
    unique case (cur_pos[1:0])
      2'd0:    want = header_first;
      2'd1:    want = header_second;
      default: want = header_third;
    endcase
  end

  always_comb begin
    active_next             = active;
    position_next           = position;
    length_seen_next        = length_seen;
    xor_whole_next          = xor_whole;
    xor_payload_next        = xor_payload;
    first_check_failed_next = first_check_failed;
    emit                    = 1'b0;
    out_verdict_next        = out_verdict;
    out_length_next         = out_length;

    if (fire && cur_active) begin
      active_next             = 1'b1;
      position_next           = cur_pos + 8'd1;
      length_seen_next        = cur_len;
      xor_whole_next          = cur_xw;
      xor_payload_next        = cur_xp;
      first_check_failed_next = cur_fcf;

      if (cur_pos < POS_LENGTH) begin
        if (s_tdata != want) begin
          emit             = 1'b1;
          out_verdict_next = V_BAD_HEADER;
          out_length_next  = '0;
        end else begin
          xor_whole_next = cur_xw ^ s_tdata;
        end
      end else if (cur_pos == POS_LENGTH) begin
        length_seen_next = s_tdata;
        if (s_tdata < MIN_LENGTH) begin
          emit             = 1'b1;
          out_verdict_next = V_SHORT;
          out_length_next  = s_tdata;
        end else begin
          xor_whole_next = cur_xw ^ s_tdata;
        end
      end else if (cur_pos == POS_PAYLOAD) begin
        xor_whole_next   = cur_xw ^ s_tdata;
        xor_payload_next = s_tdata ^ PAYLOAD_SEED;
      end else if (cur_pos < cur_len - 8'd2) begin
        xor_whole_next   = cur_xw ^ s_tdata;
        xor_payload_next = cur_xp ^ s_tdata;
      end else if (cur_pos == cur_len - 8'd2) begin
        first_check_failed_next = (s_tdata != cur_xw);
      end else begin
        emit             = 1'b1;
        out_verdict_next = (cur_fcf || (s_tdata != cur_xp)) ? V_CHECK_BAD : V_VALID;
        out_length_next  = cur_len;
      end

      // The position is left alone on a verdict, as the frame is over.
      if (emit) begin
        active_next   = 1'b0;
        position_next = cur_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active             <= 1'b0;
      position           <= '0;
      length_seen        <= '0;
      xor_whole          <= '0;
      xor_payload        <= '0;
      first_check_failed <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      active             <= active_next;
      position           <= position_next;
      length_seen        <= length_seen_next;
      xor_whole          <= xor_whole_next;
      xor_payload        <= xor_payload_next;
      first_check_failed <= first_check_failed_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_verdict <= out_verdict_next;
      out_length  <= out_length_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DW-BYTE_W-VERDICT_W){1'b0}}, out_length, out_verdict};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_bad_header_no_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_verdict == V_BAD_HEADER) |-> (out_length == '0))
    else $error("bad header verdict carries a non-zero length");

  a_short_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_verdict == V_SHORT) |-> (out_length < MIN_LENGTH))
    else $error("short length verdict with a length of seven or more");

  a_full_frame_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_verdict == V_VALID || out_verdict == V_CHECK_BAD))
      |-> (out_length >= MIN_LENGTH))
    else $error("check verdict for a frame shorter than seven");

  a_payload_length_known: assert property (@(posedge clk) disable iff (rst)
    (active && position > POS_LENGTH) |-> (length_seen >= MIN_LENGTH))
    else $error("frame past its length byte with a short length");

  a_start_takes_effect: assert property (@(posedge clk) disable iff (rst)
    (fire && s_tuser) |=> (active || out_valid))
    else $error("start word left the block idle without a verdict");

endmodule

>>> dv/xor_checked_frame_validator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_frame_validator_tb
// Self-checking bench for the XOR-checked frame validator.
// ----------------------------------------------------------------------------
// Byte-serial frames, some clean and some damaged, are queued per header
// setting. A clocked driver sends them with random gaps while the verdict
// sink stalls at random. Every accepted byte goes through a local frame
// checker, and each verdict word is compared with the oldest predicted one.
// The header registers are written and read back over the register port
// between phases, once all verdicts have arrived.
module xor_checked_frame_validator_tb;
  import xcfv_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct {
    byte_t data;
    logic  start;
  } link_word_t;

  typedef struct {
    verdict_t verdict;
    byte_t    length;
  } verdict_word_t;

  typedef enum int {
    FK_GOOD, FK_BAD_HDR, FK_SHORT, FK_BAD_CHK1, FK_BAD_CHK2, FK_BAD_BOTH, FK_CUT
  } frame_kind_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;   // [7:0] byte_value
  logic              s_tuser = 1'b0; // [0] frame_start
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_DW-1:0] m_tdata;        // [1:0] verdict, [9:2] frame_length
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  xor_checked_frame_validator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Local view of the header registers and the frame being checked.
  byte_t hdr_cfg [0:2] = '{HEADER_FIRST_RST, HEADER_SECOND_RST, HEADER_THIRD_RST};
  logic  fr_active = 1'b0;
  byte_t fr_pos = '0;
  byte_t fr_len = '0;
  byte_t xor_all = '0;
  byte_t xor_body = '0;
  logic  chk1_bad = 1'b0;

  link_word_t    tx_bytes[$];
  verdict_word_t verdict_q[$];

  int  pushed_cnt = 0;
  int  taken_cnt = 0;
  int  counted_bytes = 0;
  int  err_cnt = 0;
  int  n_settings = 1;
  int  seen_verdict [0:3] = '{0, 0, 0, 0};
  int  src_gap = 0;
  int  sink_gap = 0;
  int  idle_cycles = 0;
  bit  steady = 1'b0;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  // Walks one accepted byte through the frame checker; returns 1 when the
  // byte decides the frame.
  function automatic bit judge_byte(input byte_t b, input logic start,
                                    output verdict_t v, output byte_t len);
    v = V_VALID;
    len = '0;
    if (start) begin
      fr_active = 1'b1;
      fr_pos = '0;
      fr_len = '0;
      xor_all = '0;
      xor_body = '0;
      chk1_bad = 1'b0;
    end else if (!fr_active) begin
      return 1'b0;
    end
    if (fr_pos < POS_LENGTH) begin
      if (b != hdr_cfg[fr_pos[1:0]]) begin
        v = V_BAD_HEADER;
        fr_active = 1'b0;
        return 1'b1;
      end
      xor_all ^= b;
    end else if (fr_pos == POS_LENGTH) begin
      fr_len = b;
      if (b < MIN_LENGTH) begin
        v = V_SHORT;
        len = b;
        fr_active = 1'b0;
        return 1'b1;
      end
      xor_all ^= b;
    end else if (fr_pos == POS_PAYLOAD) begin
      xor_all ^= b;
      xor_body = b ^ PAYLOAD_SEED;
    end else if (fr_pos < fr_len - 8'd2) begin
      xor_all ^= b;
      xor_body ^= b;
    end else if (fr_pos == fr_len - 8'd2) begin
      chk1_bad = (b != xor_all);
    end else begin
      v = (chk1_bad || b != xor_body) ? V_CHECK_BAD : V_VALID;
      len = fr_len;
      fr_active = 1'b0;
      return 1'b1;
    end
    fr_pos++;
    return 1'b0;
  endfunction

  // Mostly back-to-back, often short gaps, now and then a long one.
  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_length();
    int r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(7, 20);
    if (r < 98) return $urandom_range(21, 64);
    return $urandom_range(200, 255);
  endfunction

  task automatic push_word(input byte_t data, input logic start);
    tx_bytes.push_back('{data, start});
    pushed_cnt++;
  endtask

  task automatic queue_frame(input frame_kind_t kind, input int flen);
    byte_t fb[$];
    byte_t xa;
    byte_t xb;
    int    keep;
    int    pos;
    fb.push_back(hdr_cfg[0]);
    fb.push_back(hdr_cfg[1]);
    fb.push_back(hdr_cfg[2]);
    fb.push_back(byte_t'(flen));
    keep = 4;
    if (kind != FK_SHORT) begin
      for (int i = 4; i < flen - 2; i++) fb.push_back(byte_t'($urandom));
      xa = '0;
      foreach (fb[i]) xa ^= fb[i];
      xb = PAYLOAD_SEED;
      for (int i = 4; i < fb.size(); i++) xb ^= fb[i];
      fb.push_back(xa);
      fb.push_back(xb);
      keep = fb.size();
      case (kind)
        FK_BAD_CHK1: fb[flen-2] ^= byte_t'($urandom_range(1, 255));
        FK_BAD_CHK2: fb[flen-1] ^= byte_t'($urandom_range(1, 255));
        FK_BAD_BOTH: begin
          fb[flen-2] ^= byte_t'($urandom_range(1, 255));
          fb[flen-1] ^= byte_t'($urandom_range(1, 255));
        end
        FK_BAD_HDR: begin
          pos = $urandom_range(0, 2);
          fb[pos] ^= byte_t'($urandom_range(1, 255));
          // Sometimes the rest of the frame follows and should be ignored.
          if ($urandom_range(0, 1) != 0) keep = pos + 1;
        end
        FK_CUT: keep = $urandom_range(1, flen - 1);
        default: ;
      endcase
    end
    for (int i = 0; i < keep; i++) push_word(fb[i], i == 0);
    counted_bytes += keep;
    if (kind == FK_SHORT) begin
      repeat ($urandom_range(0, 2)) push_word(byte_t'($urandom), 1'b0);
    end
  endtask

  // Random bytes with an occasional start flag.
  task automatic queue_noise(input int n);
    repeat (n) push_word(byte_t'($urandom), $urandom_range(0, 3) == 0);
  endtask

  task automatic queue_random(input int n_bytes);
    int          goal;
    int          r;
    frame_kind_t kind;
    goal = counted_bytes + n_bytes;
    while (counted_bytes < goal) begin
      r = $urandom_range(0, 99);
      if (r < 40) kind = FK_GOOD;
      else if (r < 50) kind = FK_BAD_CHK1;
      else if (r < 60) kind = FK_BAD_CHK2;
      else if (r < 65) kind = FK_BAD_BOTH;
      else if (r < 75) kind = FK_BAD_HDR;
      else if (r < 83) kind = FK_SHORT;
      else kind = FK_CUT;
      if ($urandom_range(0, 99) < 7) queue_noise($urandom_range(1, 4));
      if (kind == FK_SHORT) queue_frame(kind, $urandom_range(0, 6));
      else queue_frame(kind, pick_length());
    end
  endtask

  // Waits until every queued word is taken and every verdict has arrived,
  // then lets the pipeline settle.
  task automatic wait_settled();
    while (taken_cnt != pushed_cnt || verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input byte_t wval,
                            output logic [APB_DW-1:0] rval);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, wval};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rval = prdata;
    if (wr) hdr_cfg[idx] = wval;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_header(input logic [1:0] idx, input byte_t want);
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, idx, 8'h00, rd);
    if (rd !== {24'h0, want})
      flag_mismatch($sformatf("register %0d reads %h, want %h", idx, rd, want));
  endtask

  task automatic set_headers(input byte_t h0, input byte_t h1, input byte_t h2);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, REG_HEADER_FIRST, h0, rd);
    apb_access(1'b1, REG_HEADER_SECOND, h1, rd);
    apb_access(1'b1, REG_HEADER_THIRD, h2, rd);
    check_header(REG_HEADER_FIRST, h0);
    check_header(REG_HEADER_SECOND, h1);
    check_header(REG_HEADER_THIRD, h2);
    n_settings++;
  endtask

  // Word driver.
  always @(posedge clk) begin : drive_bytes
    link_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else if (!s_tvalid || s_tready) begin
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        w = tx_bytes.pop_front();
        s_tdata  <= w.data;
        s_tuser  <= w.start;
        s_tvalid <= 1'b1;
        src_gap = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Verdict sink back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
    end else if (sink_gap > 0) begin
      m_tready <= 1'b0;
      sink_gap--;
    end else begin
      m_tready <= 1'b1;
      sink_gap = pick_gap();
    end
  end

  // Monitor: checks verdict words first, since a verdict always belongs to an
  // earlier byte, then predicts from the byte taken at this edge.
  always @(posedge clk) begin : watch_ports
    verdict_word_t e;
    verdict_t      v;
    byte_t         l;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("verdict word %h with none pending", m_tdata));
        end else begin
          e = verdict_q.pop_front();
          if (m_tdata[1:0] !== e.verdict)
            flag_mismatch($sformatf("verdict %0d, want %0d", m_tdata[1:0], e.verdict));
          if (m_tdata[9:2] !== e.length)
            flag_mismatch($sformatf("frame_length %0d, want %0d", m_tdata[9:2], e.length));
          if (m_tdata[OUT_DW-1:10] !== '0)
            flag_mismatch($sformatf("padding bits set in %h", m_tdata));
        end
      end
      if (s_tvalid && s_tready) begin
        taken_cnt++;
        if (judge_byte(s_tdata, s_tuser, v, l)) begin
          verdict_q.push_back('{v, l});
          seen_verdict[v]++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("xor_checked_frame_validator_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    check_header(REG_HEADER_FIRST, HEADER_FIRST_RST);
    check_header(REG_HEADER_SECOND, HEADER_SECOND_RST);
    check_header(REG_HEADER_THIRD, HEADER_THIRD_RST);

    // Directed: ignored idle byte, shortest and just-too-short lengths,
    // header failure, both check bytes bad, a restart mid-frame.
    push_word(8'hFF, 1'b0);
    queue_frame(FK_SHORT, 6);
    queue_frame(FK_BAD_HDR, 7);
    queue_frame(FK_GOOD, 7);
    queue_frame(FK_BAD_BOTH, 7);
    queue_frame(FK_CUT, 7);
    queue_frame(FK_SHORT, 0);
    wait_settled();

    set_headers(8'h00, 8'h00, 8'h00);
    queue_random(150);
    wait_settled();

    set_headers(8'hFF, 8'hFF, 8'hFF);
    queue_random(150);
    wait_settled();

    set_headers(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
    queue_random(150);
    // Hold the sender until every verdict is home, then carry on.
    wait_settled();
    queue_random(150);
    wait_settled();

    set_headers(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
    steady = 1'b1;
    queue_random(150);
    wait_settled();
    steady = 1'b0;
    queue_random(150);
    wait_settled();
    repeat (10) @(posedge clk);

    $display("covered %0d bytes under %0d header settings", taken_cnt, n_settings);
    $display("verdicts: valid %0d, bad header %0d, check mismatch %0d, short %0d",
             seen_verdict[V_VALID], seen_verdict[V_BAD_HEADER],
             seen_verdict[V_CHECK_BAD], seen_verdict[V_SHORT]);
    if (err_cnt == 0) begin
      $display("xor_checked_frame_validator_tb: PASS");
    end else begin
      $display("xor_checked_frame_validator_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/xcfv_pkg.sv
rtl/core/xor_checked_frame_validator.sv
dv/xor_checked_frame_validator_tb.sv
